>>> rtl/ean_pkg.sv
// Shared types, constants and code tables for the EAN-13 module encoder.
package ean_pkg;

  // Digits per symbol and positions of the special digits
  localparam int unsigned NumDigits = 13;
  localparam logic [3:0]  PosFirst  = 4'd0;
  localparam logic [3:0]  PosStart  = 4'd1;
  localparam logic [3:0]  PosMid    = 4'd6;
  localparam logic [3:0]  PosEnd    = 4'(NumDigits - 1);
  localparam logic [3:0]  MaxDigit  = 4'd9;

  // Fixed module groups
  localparam logic [9:0]  QuietBars  = 10'b0000000000;
  localparam logic [3:0]  QuietCount = 4'd10;
  localparam logic [9:0]  EdgeGuard  = 10'b0000000101;
  localparam logic [3:0]  EdgeCount  = 4'd3;
  localparam logic [9:0]  MidGuard   = 10'b0000001010;
  localparam logic [3:0]  MidCount   = 4'd5;
  localparam logic [3:0]  CodeCount  = 4'd7;
  localparam logic [9:0]  ErrBars    = 10'b0000000000;
  localparam logic [3:0]  ErrCount   = 4'd1;
  localparam logic [6:0]  RInvert    = 7'h7F;

  // Command queue depth
  localparam int unsigned QueueAw    = 1;
  localparam int unsigned QueueDepth = 1 << QueueAw;

  // What the back end has to emit for one digit
  typedef enum logic [2:0] {
    CMD_ERR   = 3'd0,
    CMD_START = 3'd1,
    CMD_PLAIN = 3'd2,
    CMD_MID   = 3'd3,
    CMD_END   = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [6:0] code;
  } cmd_t;

  // L code (odd parity) of a digit
  function automatic logic [6:0] code_l(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'd0: c = 7'h0D;
      4'd1: c = 7'h19;
      4'd2: c = 7'h13;
      4'd3: c = 7'h3D;
      4'd4: c = 7'h23;
      4'd5: c = 7'h31;
      4'd6: c = 7'h2F;
      4'd7: c = 7'h3B;
      4'd8: c = 7'h37;
      4'd9: c = 7'h0B;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // G code (even parity) of a digit
  function automatic logic [6:0] code_g(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'd0: c = 7'h27;
      4'd1: c = 7'h33;
      4'd2: c = 7'h1B;
      4'd3: c = 7'h21;
      4'd4: c = 7'h1D;
      4'd5: c = 7'h39;
      4'd6: c = 7'h05;
      4'd7: c = 7'h11;
      4'd8: c = 7'h09;
      4'd9: c = 7'h17;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Parity pattern selected by the first digit, bit 5 for the second digit
  function automatic logic [5:0] first_parity(input logic [3:0] d);
    logic [5:0] p;
    case (d)
      4'd0: p = 6'h00;
      4'd1: p = 6'h0B;
      4'd2: p = 6'h0D;
      4'd3: p = 6'h0E;
      4'd4: p = 6'h13;
      4'd5: p = 6'h19;
      4'd6: p = 6'h1C;
      4'd7: p = 6'h15;
      4'd8: p = 6'h16;
      4'd9: p = 6'h1A;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/ean13_module_encoder_top.sv
// EAN-13 module encoder top level: digit stream in, module group stream out.
//
// Feed the 13 digits of an EAN-13 number one per request on the slave side;
// set tuser to force a digit to be taken as the first one of a new symbol.
// The first digit produces no output and only selects the L/G parity pattern.
// Each later digit produces one to three module groups on the master side
// (quiet zone and start guard before the second digit, middle guard after the
// seventh, end guard and closing quiet zone after the thirteenth); tlast marks
// the last group of each digit. A digit above 9 produces one error group and
// aborts the symbol. The front end takes a digit whenever the queue has room;
// the back end serializer emits one group per cycle unless the output stalls,
// so a full symbol's 12 coded digits give 17 groups, with a two-entry command
// queue between the two so the input keeps flowing while output stalls.
module ean13_module_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] digit, [7:4] zero
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [9:0] bars, [13:10] bar_count,
                                      // [14] symbol_end, [15] digit_error
  output logic        m_axis_tlast
);
  import ean_pkg::*;

  logic       push;
  cmd_t       push_cmd;
  logic       push_ready;
  logic       pop;
  cmd_t       pop_cmd;
  logic       pop_valid;
  logic [9:0] bars;
  logic [3:0] bar_count;
  logic       symbol_end;
  logic       digit_error;

  ean_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .digit_i      (s_axis_tdata[3:0]),
    .restart_i    (s_axis_tuser),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  ean_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_cmd_o    (pop_cmd),
    .pop_valid_o  (pop_valid)
  );

  ean_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_cmd_i     (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .bars_o        (bars),
    .bar_count_o   (bar_count),
    .symbol_end_o  (symbol_end),
    .digit_error_o (digit_error),
    .last_o        (m_axis_tlast)
  );

  // Pack output fields
  assign m_axis_tdata = {digit_error, symbol_end, bar_count, bars};

endmodule

>>> rtl/ean_front.sv
// Front end: accepts digits, tracks position and parity, issues commands.
module ean_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [3:0]    digit_i,
  input  logic          restart_i,
  output logic          push_o,
  output ean_pkg::cmd_t push_cmd_o,
  input  logic          push_ready_i
);
  import ean_pkg::*;

  logic [3:0] pos_q, pos_d;
  logic [5:0] par_q, par_d;
  logic [3:0] pos_eff;
  logic       accept;
  logic       bad_digit;
  logic       g_sel;
  logic [2:0] par_idx;
  logic [6:0] code;
  cmd_t       cmd;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign bad_digit  = digit_i > MaxDigit;

  // Fold restart and out-of-range position into a first digit
  assign pos_eff = (restart_i || pos_q > PosEnd) ? PosFirst : pos_q;

  // Pick L, G or R code
  assign par_idx = 3'(4'd6 - pos_eff);
  assign g_sel   = par_q[par_idx];
  always_comb begin
    if (pos_eff <= PosMid) begin
      code = g_sel ? code_g(digit_i) : code_l(digit_i);
    end else begin
      code = code_l(digit_i) ^ RInvert;
    end
  end

  // Classify the digit
  always_comb begin
    cmd.code = code;
    if (bad_digit) begin
      cmd.kind = CMD_ERR;
    end else if (pos_eff == PosStart) begin
      cmd.kind = CMD_START;
    end else if (pos_eff == PosMid) begin
      cmd.kind = CMD_MID;
    end else if (pos_eff == PosEnd) begin
      cmd.kind = CMD_END;
    end else begin
      cmd.kind = CMD_PLAIN;
    end
  end

  // A valid first digit emits nothing
  assign push_o     = accept && (bad_digit || pos_eff != PosFirst);
  assign push_cmd_o = cmd;

  // Advance position and parity state
  always_comb begin
    pos_d = pos_q;
    par_d = par_q;
    if (accept) begin
      if (bad_digit) begin
        pos_d = PosFirst;
        par_d = '0;
      end else if (pos_eff == PosFirst) begin
        par_d = first_parity(digit_i);
        pos_d = PosStart;
      end else if (pos_eff == PosEnd) begin
        pos_d = PosFirst;
      end else begin
        pos_d = pos_eff + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosFirst;
      par_q <= '0;
    end else begin
      pos_q <= pos_d;
      par_q <= par_d;
    end
  end

  // Position never leaves the symbol
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosEnd)
    else $error("digit position out of range");

  // An invalid digit clears the symbol state
  a_err_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && bad_digit) |=> (pos_q == PosFirst && par_q == '0))
    else $error("invalid digit did not abort symbol");

  // Every accepted digit past the first issues a command
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !restart_i && pos_q != PosFirst) |-> push_o)
    else $error("digit dropped without command");

endmodule

>>> rtl/ean_fifo.sv
// Short command queue between front end and back end.
module ean_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ean_pkg::cmd_t push_cmd_i,
  output logic          push_ready_o,
  input  logic          pop_i,
  output ean_pkg::cmd_t pop_cmd_o,
  output logic          pop_valid_o
);
  import ean_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != (QueueAw + 1)'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Fill level stays within depth
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QueueAw + 1)'(QueueDepth))
    else $error("queue overflow");

  // No request is pushed into a full queue
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> push_ready_o)
    else $error("request pushed into full queue");

  // No request is popped from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("request popped from empty queue");

endmodule

>>> rtl/ean_back.sv
// Back end: expands commands into module groups behind an output register.
module ean_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  input  ean_pkg::cmd_t pop_cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [9:0]    bars_o,
  output logic [3:0]    bar_count_o,
  output logic          symbol_end_o,
  output logic          digit_error_o,
  output logic          last_o
);
  import ean_pkg::*;

  cmd_t       cmd_q;
  logic       busy_q, busy_d;
  logic [1:0] step_q, step_d;
  logic       out_free;
  logic       emit;

  logic [9:0] g_bars;
  logic [3:0] g_count;
  logic       g_end, g_err, g_last;

  logic       valid_q;
  logic [9:0] bars_q;
  logic [3:0] count_q;
  logic       end_q, err_q, last_q;

  assign out_free = !valid_q || out_ready_i;
  assign emit     = busy_q && out_free;
  assign pop_o    = pop_valid_i && (!busy_q || (emit && g_last));

  // Select the group for the current step
  always_comb begin
    g_bars  = {3'b000, cmd_q.code};
    g_count = CodeCount;
    g_end   = 1'b0;
    g_err   = 1'b0;
    g_last  = 1'b0;
    case (cmd_q.kind)
      CMD_ERR: begin
        g_bars  = ErrBars;
        g_count = ErrCount;
        g_err   = 1'b1;
        g_last  = 1'b1;
      end
      CMD_START: begin
        if (step_q == 2'd0) begin
          g_bars  = QuietBars;
          g_count = QuietCount;
        end else if (step_q == 2'd1) begin
          g_bars  = EdgeGuard;
          g_count = EdgeCount;
        end else begin
          g_last  = 1'b1;
        end
      end
      CMD_PLAIN: begin
        g_last = 1'b1;
      end
      CMD_MID: begin
        if (step_q != 2'd0) begin
          g_bars  = MidGuard;
          g_count = MidCount;
          g_last  = 1'b1;
        end
      end
      CMD_END: begin
        if (step_q == 2'd1) begin
          g_bars  = EdgeGuard;
          g_count = EdgeCount;
        end else if (step_q == 2'd2) begin
          g_bars  = QuietBars;
          g_count = QuietCount;
          g_end   = 1'b1;
          g_last  = 1'b1;
        end
      end
      default: begin
        g_last = 1'b1;
      end
    endcase
  end

  // Advance through the groups, load the next command on the last one or when idle
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (emit) begin
      if (g_last) begin
        busy_d = 1'b0;
        step_d = 2'd0;
      end else begin
        step_d = step_q + 2'd1;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      step_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (out_free) begin
        valid_q <= emit;
      end
    end
  end

  // Hold command and output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= pop_cmd_i;
    end
    if (emit) begin
      bars_q  <= g_bars;
      count_q <= g_count;
      end_q   <= g_end;
      err_q   <= g_err;
      last_q  <= g_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign bars_o        = bars_q;
  assign bar_count_o   = count_q;
  assign symbol_end_o  = end_q;
  assign digit_error_o = err_q;
  assign last_o        = last_q;

  // A command never needs a fourth group
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q != 2'd3)
    else $error("group step overrun");

  // The end-of-symbol group is always the last of its request
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && g_end) |-> g_last)
    else $error("symbol end not on last group");

  // A new command is only taken when the previous one is finished
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && busy_q) |-> (emit && g_last))
    else $error("command overwritten");

endmodule
